>>> src/fixed_partition_fit_allocator_core_assert.svh
// Assertion macros for the fixed-partition allocator.
// Included by the top level; needs nothing else.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FPFA_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fpfa: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define FPFA_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fpfa: next-cycle check failed");

`endif

>>> src/fpfa_pkg.sv
// Shared constants, codes and types of the fixed-partition allocator.
// No dependencies; the interfaces, the cell and the top level refer to it by scoped names.
package fpfa_pkg;

  localparam int NUM_BLOCKS    = 4;
  localparam int NUM_PROCESSES = 16;
  localparam int SIZE_BITS     = 16;

  // Fixed field widths of the channels
  localparam int ACTION_W = 1;
  localparam int PID_W    = 4;
  localparam int REQ_W    = 16;
  localparam int STATUS_W = 3;
  localparam int BIDX_W   = 2;
  localparam int GRANT_W  = 16;

  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int PROC_IDX_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int CMP_W      = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

  // Configuration port
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 5;
  localparam int REG_IDX_W   = 3;
  localparam int MODE_W      = 2;
  localparam int BIU_W       = 3;
  localparam int SIZE_FLD_W  = 16;
  localparam int NUM_SIZE_REGS = 4;

  localparam logic [REG_IDX_W-1:0] REG_FIT_MODE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BLOCKS_IN_USE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_BLOCK_0  = 3'd2;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic [BIU_W-1:0] BIU_RESET = 3'd4;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOC = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HOLDS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE  = 3'd4;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                  vld;
    logic                  found;
    logic [IDX_W-1:0]      idx;
    logic [SIZE_BITS-1:0]  size;
    logic [REQ_W-1:0]      req;
    logic [MODE_W-1:0]     mode;
    logic [CNT_W-1:0]      limit;
  } cand_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic size_we;
    logic set_busy;
    logic clr_busy;
  } cell_ctl_t;

endpackage

>>> src/fpfa_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on fpfa_pkg for field widths.
interface fpfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [fpfa_pkg::ACTION_W-1:0] action;
  logic [fpfa_pkg::PID_W-1:0]    process_id;
  logic [fpfa_pkg::REQ_W-1:0]    request_size;

  modport source (output valid, action, process_id, request_size, input ready);
  modport sink   (input valid, action, process_id, request_size, output ready);
endinterface

interface fpfa_res_if;
  logic                          valid;
  logic                          ready;
  logic [fpfa_pkg::STATUS_W-1:0] status;
  logic [fpfa_pkg::BIDX_W-1:0]   block_index;
  logic [fpfa_pkg::GRANT_W-1:0]  granted_size;

  modport source (output valid, status, block_index, granted_size, input ready);
  modport sink   (input valid, status, block_index, granted_size, output ready);
endinterface

>>> src/fpfa_cell.sv
// One partition cell: holds its size and busy bit, folds itself into the
// passing search token and registers it for the next cell. Uses fpfa_pkg.
module fpfa_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fpfa_pkg::IDX_W-1:0]     cell_idx,
  input  fpfa_pkg::cell_ctl_t            ctl,
  input  logic [fpfa_pkg::SIZE_BITS-1:0] size_wdata,
  input  fpfa_pkg::cand_t                cand_i,
  output fpfa_pkg::cand_t                cand_o,
  output logic [fpfa_pkg::SIZE_BITS-1:0] size_o,
  output logic                           busy_o
);

  logic [fpfa_pkg::SIZE_BITS-1:0] size_r;
  logic                           busy_r;
  fpfa_pkg::cand_t                cand_r, cand_nxt;
  logic                           fits;
  logic                           take;

  always_comb begin
    fits = (fpfa_pkg::CNT_W'(cell_idx) < cand_i.limit) && !busy_r &&
           (fpfa_pkg::CMP_W'(size_r) >= fpfa_pkg::CMP_W'(cand_i.req));
    take = 1'b0;
    if (fits) begin
      if (!cand_i.found) begin
        take = 1'b1;
      end else if (cand_i.mode == fpfa_pkg::FIT_BEST) begin
        take = size_r < cand_i.size;
      end else if (cand_i.mode == fpfa_pkg::FIT_WORST) begin
        take = size_r > cand_i.size;
      end
    end
    cand_nxt = cand_i;
    if (take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.idx   = cell_idx;
      cand_nxt.size  = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= '0;
      busy_r     <= 1'b0;
      cand_r.vld <= 1'b0;
    end else begin
      if (ctl.size_we) begin
        size_r <= size_wdata;
      end
      if (ctl.set_busy) begin
        busy_r <= 1'b1;
      end else if (ctl.clr_busy) begin
        busy_r <= 1'b0;
      end
      cand_r.vld <= cand_nxt.vld;
    end
  end

  // Token payload: no reset
  always_ff @(posedge clk) begin
    cand_r.found <= cand_nxt.found;
    cand_r.idx   <= cand_nxt.idx;
    cand_r.size  <= cand_nxt.size;
    cand_r.req   <= cand_nxt.req;
    cand_r.mode  <= cand_nxt.mode;
    cand_r.limit <= cand_nxt.limit;
  end

  assign cand_o = cand_r;
  assign size_o = size_r;
  assign busy_o = busy_r;

endmodule

>>> src/fixed_partition_fit_allocator_core.sv
// Flow: one request at a time; a new request is taken only after the last
//   result has entered the output register. The search token walks the cell
//   chain one partition per cycle, then the commit registers the result.
// Reset (rst_n low, synchronous): every partition free, no process owns one,
//   fit_mode first fit, blocks_in_use 4, partition sizes zero.
// Depends on fpfa_pkg, fpfa_ifs, fpfa_cell and the assertion macro header.
`include "fixed_partition_fit_allocator_core_assert.svh"

module fixed_partition_fit_allocator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  fpfa_req_if.sink                     in_ch,
  fpfa_res_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fpfa_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [fpfa_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [fpfa_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int NB = fpfa_pkg::NUM_BLOCKS;
  localparam int NP = fpfa_pkg::NUM_PROCESSES;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Configuration registers
  logic [fpfa_pkg::MODE_W-1:0]    fit_mode_r;
  logic [fpfa_pkg::BIU_W-1:0]     biu_r;
  logic                           cfg_wr;
  logic [fpfa_pkg::REG_IDX_W-1:0] reg_idx;
  logic [fpfa_pkg::SIZE_BITS-1:0] size_wdata;
  logic [fpfa_pkg::CNT_W-1:0]     limit_c;

  // Latched request
  logic [fpfa_pkg::ACTION_W-1:0]  act_r;
  logic [fpfa_pkg::PID_W-1:0]     pid_r;
  logic [fpfa_pkg::PROC_IDX_W-1:0] pidx;
  logic                           pid_ok;

  // Ownership table, one entry per process
  logic [NP-1:0]                  own_vld_r;
  logic [fpfa_pkg::IDX_W-1:0]     own_idx_r [NP];
  logic                           own_vld_c;
  logic [fpfa_pkg::IDX_W-1:0]     own_idx_c;

  // Cell chain
  fpfa_pkg::cand_t                inj;
  fpfa_pkg::cand_t                chain [NB];
  fpfa_pkg::cell_ctl_t            ctl [NB];
  logic [fpfa_pkg::SIZE_BITS-1:0] cell_size [NB];
  logic [NB-1:0]                  busy_vec;
  logic [NB-1:0]                  chain_vld;
  fpfa_pkg::cand_t                last;

  // Commit and result
  logic                           in_acc;
  logic                           commit_go;
  logic                           alloc_ok;
  logic                           free_ok;
  logic                           out_free;
  logic [fpfa_pkg::STATUS_W-1:0]  res_status;
  logic [fpfa_pkg::IDX_W-1:0]     res_idx;
  logic [fpfa_pkg::SIZE_BITS-1:0] res_size;
  logic [fpfa_pkg::STATUS_W-1:0]  hold_status_r;
  logic [fpfa_pkg::IDX_W-1:0]     hold_idx_r;
  logic [fpfa_pkg::SIZE_BITS-1:0] hold_size_r;
  logic                           out_vld_r;
  logic [fpfa_pkg::STATUS_W-1:0]  out_status_r;
  logic [fpfa_pkg::IDX_W-1:0]     out_idx_r;
  logic [fpfa_pkg::SIZE_BITS-1:0] out_size_r;

  // ---------------------------------------------------------------------
  // Configuration port: writes complete in the access phase, no wait states
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[fpfa_pkg::PADDR_W-1:2];
  assign size_wdata = fpfa_pkg::SIZE_BITS'(cfg_pwdata[fpfa_pkg::SIZE_FLD_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= fpfa_pkg::FIT_FIRST;
      biu_r      <= fpfa_pkg::BIU_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == fpfa_pkg::REG_FIT_MODE) begin
        fit_mode_r <= cfg_pwdata[fpfa_pkg::MODE_W-1:0];
      end
      if (reg_idx == fpfa_pkg::REG_BLOCKS_IN_USE) begin
        biu_r <= cfg_pwdata[fpfa_pkg::BIU_W-1:0];
      end
    end
  end

  // Read-back; size registers beyond the built partitions read as zero
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      fpfa_pkg::REG_FIT_MODE:      cfg_prdata = fpfa_pkg::DATA_W'(fit_mode_r);
      fpfa_pkg::REG_BLOCKS_IN_USE: cfg_prdata = fpfa_pkg::DATA_W'(biu_r);
      default: begin
        for (int k = 0; k < NB; k++) begin
          if (k < fpfa_pkg::NUM_SIZE_REGS &&
              reg_idx == fpfa_pkg::REG_SIZE_BLOCK_0 + fpfa_pkg::REG_IDX_W'(k)) begin
            cfg_prdata = fpfa_pkg::DATA_W'(cell_size[k]);
          end
        end
      end
    endcase
  end

  // Saturate the partition count at the number of cells
  assign limit_c = (32'(biu_r) > NB) ? fpfa_pkg::CNT_W'(NB) : fpfa_pkg::CNT_W'(biu_r);

  // ---------------------------------------------------------------------
  // Request acceptance: the beat itself enters the first cell as a token
  // ---------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    inj       = '0;
    inj.vld   = in_acc;
    inj.req   = in_ch.request_size;
    inj.mode  = fit_mode_r;
    inj.limit = limit_c;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_ch.action;
      pid_r <= in_ch.process_id;
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain: one partition per cell, token advances one cell a cycle
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < NB; k++) begin : g_cell
    fpfa_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (fpfa_pkg::IDX_W'(k)),
      .ctl        (ctl[k]),
      .size_wdata (size_wdata),
      .cand_i     ((k == 0) ? inj : chain[(k == 0) ? 0 : k - 1]),
      .cand_o     (chain[k]),
      .size_o     (cell_size[k]),
      .busy_o     (busy_vec[k])
    );
    assign chain_vld[k] = chain[k].vld;
  end

  assign last = chain[NB-1];

  // ---------------------------------------------------------------------
  // Commit: decide the status and update ownership once the token leaves
  // the last cell
  // ---------------------------------------------------------------------
  assign pid_ok    = (32'(pid_r) < NP);
  assign pidx      = fpfa_pkg::PROC_IDX_W'(pid_r);
  assign own_vld_c = pid_ok && own_vld_r[pidx];
  assign own_idx_c = own_idx_r[pidx];
  assign commit_go = (state_r == S_SCAN) && last.vld;

  always_comb begin
    alloc_ok   = 1'b0;
    free_ok    = 1'b0;
    res_status = fpfa_pkg::ST_NOFIT;
    res_idx    = '0;
    res_size   = '0;
    if (act_r == fpfa_pkg::ACT_FREE) begin
      if (own_vld_c) begin
        free_ok    = 1'b1;
        res_status = fpfa_pkg::ST_FREED;
        res_idx    = own_idx_c;
        res_size   = cell_size[own_idx_c];
      end else begin
        res_status = fpfa_pkg::ST_NONE;
      end
    end else if (!pid_ok) begin
      res_status = fpfa_pkg::ST_NOFIT;
    end else if (own_vld_c) begin
      res_status = fpfa_pkg::ST_HOLDS;
    end else if (last.found) begin
      alloc_ok   = 1'b1;
      res_status = fpfa_pkg::ST_ALLOC;
      res_idx    = last.idx;
      res_size   = last.size;
    end
  end

  // Per-cell control: size writes from the config port, busy from commit
  always_comb begin
    for (int k = 0; k < NB; k++) begin
      ctl[k].size_we  = cfg_wr && (k < fpfa_pkg::NUM_SIZE_REGS) &&
                        (reg_idx == fpfa_pkg::REG_SIZE_BLOCK_0 + fpfa_pkg::REG_IDX_W'(k));
      ctl[k].set_busy = commit_go && alloc_ok && (last.idx == fpfa_pkg::IDX_W'(k));
      ctl[k].clr_busy = commit_go && free_ok && (own_idx_c == fpfa_pkg::IDX_W'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_vld_r <= '0;
    end else if (commit_go && alloc_ok) begin
      own_vld_r[pidx] <= 1'b1;
    end else if (commit_go && free_ok) begin
      own_vld_r[pidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go && alloc_ok) begin
      own_idx_r[pidx] <= last.idx;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and output register; hold the result if the sink stalls
  // ---------------------------------------------------------------------
  assign out_free = !out_vld_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SCAN;
      S_SCAN: if (commit_go) state_nxt = out_free ? S_IDLE : S_HOLD;
      S_HOLD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((commit_go || state_r == S_HOLD) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go && !out_free) begin
      hold_status_r <= res_status;
      hold_idx_r    <= res_idx;
      hold_size_r   <= res_size;
    end
    if (commit_go && out_free) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_size_r   <= res_size;
    end else if (state_r == S_HOLD && out_free) begin
      out_status_r <= hold_status_r;
      out_idx_r    <= hold_idx_r;
      out_size_r   <= hold_size_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.block_index  = fpfa_pkg::BIDX_W'(out_idx_r);
  assign out_ch.granted_size = fpfa_pkg::GRANT_W'(out_size_r);

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // One request in flight: never more than one token in the chain
  `FPFA_ASSERT_NOW(a_one_token, clk, rst_n, 1'b1, $countones(chain_vld) <= 1)
  // A token leaves the chain only while the sequencer waits for it
  `FPFA_ASSERT_NOW(a_token_in_scan, clk, rst_n, last.vld, state_r == S_SCAN)
  // Every owning process holds exactly one busy partition
  `FPFA_ASSERT_NOW(a_owner_busy, clk, rst_n, 1'b1,
                   $countones(own_vld_r) == $countones(busy_vec))
  // An accepted beat starts a scan
  `FPFA_ASSERT_NEXT(a_accept_scan, clk, rst_n, in_acc, state_r == S_SCAN)

endmodule
